### design/k_queues_shared_buffer_macros.svh
// Assertion macros for the shared-buffer queue block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef K_QUEUES_SHARED_BUFFER_MACROS_SVH
`define K_QUEUES_SHARED_BUFFER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KQSB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KQSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/kqsb_pkg.sv
// Package for the shared-buffer queue block: sizes, link entry type, commands.
// No dependencies.
`timescale 1ns / 1ps

package kqsb_pkg;

  localparam int SLOTS     = 16;
  localparam int QUEUES    = 4;
  localparam int DATA_BITS = 32;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int QUEUE_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] idx;
  } link_t;

endpackage

### design/k_queues_shared_buffer.sv
// Several FIFO queues threaded as linked lists through one shared slot store.
// Result registered on out_valid when the busy state finishes (held off while the output stalls);
// one item at a time: the link memory is read on transfer and written back on finish.
// Reset: synchronous; afterwards a pass over all SLOTS (16) slots rebuilds the free list
// in the link memory, with in_ready low throughout. Depends on kqsb_pkg and the macros.
`timescale 1ns / 1ps
`include "k_queues_shared_buffer_macros.svh"

module k_queues_shared_buffer
  import kqsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [1:0]  queue_id,
  input  logic [31:0] push_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [31:0] pop_value
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } state_t;

  state_t state;

  link_t                 link_mem [SLOTS];
  logic [DATA_BITS-1:0]  data_mem [SLOTS];
  link_t                 link_rd;
  logic [DATA_BITS-1:0]  data_rd;

  logic [SLOT_W-1:0]     head    [QUEUES];
  logic [QUEUES-1:0]     head_ok;
  logic [SLOT_W-1:0]     tail    [QUEUES];
  logic [SLOT_W-1:0]     free_head;
  logic                  free_ok;
  logic [SLOT_W-1:0]     clr_idx;

  logic                  cmd_r;
  logic [QUEUE_W-1:0]    q_r;
  logic                  in_range_r;
  logic [DATA_BITS-1:0]  val_r;

  logic                  accept;
  logic                  finish;
  logic [QUEUE_W-1:0]    q_in;
  logic                  in_range;
  logic [SLOT_W-1:0]     rd_addr;
  logic                  push_ok;
  logic                  pop_ok;
  logic                  link_we;
  logic [SLOT_W-1:0]     link_wa;
  link_t                 link_wd;
  logic                  data_we;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state == ST_BUSY) && (!out_valid || out_ready);
  assign q_in     = QUEUE_W'(queue_id);
  assign in_range = (32'(queue_id) < QUEUES);

  always_comb begin
    rd_addr = '0;
    if (in_range) begin
      rd_addr = (command == CMD_POP) ? head[q_in] : free_head;
    end
  end

  assign push_ok = in_range_r && (cmd_r == CMD_PUSH) && free_ok;
  assign pop_ok  = in_range_r && (cmd_r == CMD_POP) && head_ok[q_r];

  always_comb begin
    link_we = 1'b0;
    link_wa = '0;
    link_wd = '0;
    data_we = 1'b0;
    if (state == ST_CLEAR) begin
      link_we     = 1'b1;
      link_wa     = clr_idx;
      link_wd.ok  = (clr_idx != SLOT_W'(SLOTS - 1));
      link_wd.idx = clr_idx + 1'b1;
    end else if (finish && push_ok) begin
      data_we     = 1'b1;
      link_we     = head_ok[q_r];
      link_wa     = tail[q_r];
      link_wd.ok  = 1'b1;
      link_wd.idx = free_head;
    end else if (finish && pop_ok) begin
      link_we     = 1'b1;
      link_wa     = head[q_r];
      link_wd.ok  = free_ok;
      link_wd.idx = free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (accept) begin
      link_rd <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[free_head] <= val_r;
    end
    if (accept) begin
      data_rd <= data_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      head_ok   <= '0;
      free_head <= '0;
      free_ok   <= 1'b1;
      out_valid <= 1'b0;
      ok        <= 1'b0;
      pop_value <= '0;
    end else begin
      if (out_valid && out_ready && !finish) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SLOT_W'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_r      <= command;
            q_r        <= q_in;
            in_range_r <= in_range;
            val_r      <= push_value[DATA_BITS-1:0];
            state      <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (finish) begin
            out_valid <= 1'b1;
            ok        <= push_ok || pop_ok;
            pop_value <= pop_ok ? 32'($signed(data_rd)) : '0;
            if (push_ok) begin
              free_head <= link_rd.idx;
              free_ok   <= link_rd.ok;
              if (!head_ok[q_r]) begin
                head[q_r]    <= free_head;
                head_ok[q_r] <= 1'b1;
              end
              tail[q_r] <= free_head;
            end else if (pop_ok) begin
              if (head[q_r] == tail[q_r]) begin
                head_ok[q_r] <= 1'b0;
              end else begin
                head[q_r] <= link_rd.idx;
              end
              free_head <= head[q_r];
              free_ok   <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `KQSB_ASSERT_NEXT(a_finish_out, clk, rst, finish, out_valid && (state == ST_IDLE), "result lost")
  `KQSB_ASSERT_NEXT(a_push_head, clk, rst, finish && push_ok, head_ok[q_r], "push left queue empty")
  `KQSB_ASSERT_NEXT(a_pop_free, clk, rst, finish && pop_ok, free_ok, "pop lost freed slot")
  `KQSB_ASSERT_SAME(a_fail_zero, clk, rst, out_valid && !ok, pop_value == '0, "failed op with data")

endmodule

### dv/k_queues_shared_buffer_tb.sv
// Self-checking bench for k_queues_shared_buffer: directed and random push/pop traffic.
// Predicts every result from a local linked-list queue model and scores it in order.
// Depends on kqsb_pkg and the block's RTL.
`timescale 1ns / 1ps

module k_queues_shared_buffer_tb;
  import kqsb_pkg::*;

  localparam int       HOLD_CYCLES   = 150;
  localparam int       DRAIN_CYCLES  = 8;
  localparam int       RANDOM_ITEMS  = 650;
  localparam int       IDLE_PERCENT  = 14;
  localparam int       CALM_FIRST    = 420;
  localparam int       CALM_LAST     = 540;
  localparam int       HOLD_AT_ITEM  = 200;
  localparam int       MAX_REPORTS   = 10;

  typedef struct packed {
    logic        ok;
    logic [31:0] value;
  } queue_result_t;

  class queue_scoreboard;
    logic [DATA_BITS-1:0] slot_data [SLOTS];
    link_t                slot_link [SLOTS];
    link_t                head      [QUEUES];
    logic [SLOT_W-1:0]    tail      [QUEUES];
    link_t                free_head;
    queue_result_t        awaited[$];
    int                   errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_data[i] = '0;
        slot_link[i].ok = (i + 1 < SLOTS);
        slot_link[i].idx = SLOT_W'(i + 1);
      end
      for (int i = 0; i < QUEUES; i++) begin
        head[i] = '0;
        tail[i] = '0;
      end
      free_head = '{ok: 1'b1, idx: '0};
      errors = 0;
    endfunction

    function void note_transfer(logic cmd, logic [1:0] q, logic [31:0] data);
      queue_result_t     res;
      logic [SLOT_W-1:0] s;
      res = '0;
      if (cmd == CMD_PUSH) begin
        if (free_head.ok) begin
          s = free_head.idx;
          free_head = slot_link[s];
          if (head[q].ok) begin
            slot_link[tail[q]] = '{ok: 1'b1, idx: s};
          end else begin
            head[q] = '{ok: 1'b1, idx: s};
          end
          tail[q] = s;
          slot_link[s] = '0;
          slot_data[s] = data[DATA_BITS-1:0];
          res.ok = 1'b1;
        end
      end else begin
        if (head[q].ok) begin
          s = head[q].idx;
          head[q] = slot_link[s];
          slot_link[s] = free_head;
          free_head = '{ok: 1'b1, idx: s};
          res.value = 32'(signed'(slot_data[s]));
          res.ok = 1'b1;
        end
      end
      awaited.push_back(res);
    endfunction

    function void check_result(logic got_ok, logic [31:0] got_value);
      queue_result_t exp;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: ok=%0b pop_value=%h", got_ok, got_value);
        return;
      end
      exp = awaited.pop_front();
      if (got_ok !== exp.ok) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ok mismatch: expected %0b, actual %0b", exp.ok, got_ok);
      end
      if (got_value !== exp.value) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("pop_value mismatch: expected %h, actual %h", exp.value, got_value);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [1:0]  queue_id;
  logic [31:0] push_value;
  logic        out_valid;
  logic        out_ready;
  logic        ok;
  logic [31:0] pop_value;

  queue_scoreboard sb;
  int              sent_cnt;
  bit              idle_on;
  bit              hold_req;

  k_queues_shared_buffer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .queue_id   (queue_id),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .pop_value  (pop_value)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic send_item(logic cmd, logic [1:0] q, logic [31:0] data);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    queue_id   <= q;
    push_value <= data;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(cmd, q, data);
    sent_cnt++;
    idle_on  = !(sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST);
    if (sent_cnt == HOLD_AT_ITEM)
      hold_req = 1'b1;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_directed();
    send_item(CMD_POP, 2'd0, $urandom);
    send_item(CMD_PUSH, 2'd0, 32'h7fff_ffff);
    send_item(CMD_PUSH, 2'd1, 32'h8000_0000);
    send_item(CMD_PUSH, 2'd2, 32'h0000_0000);
    send_item(CMD_PUSH, 2'd3, 32'hffff_ffff);
    // fill the remaining slots, then push into a full store
    for (int i = 0; i < SLOTS - 4; i++)
      send_item(CMD_PUSH, 2'($urandom_range(QUEUES - 1)), $urandom);
    send_item(CMD_PUSH, 2'd1, $urandom);
    send_item(CMD_POP, 2'd3, $urandom);
    send_item(CMD_POP, 2'd2, $urandom);
    send_item(CMD_POP, 2'd1, $urandom);
    send_item(CMD_POP, 2'd0, $urandom);
    send_item(CMD_POP, 2'd3, $urandom);
  endtask

  task automatic run_random();
    int push_bias;
    int focus;
    logic [1:0] q;
    push_bias = 50;
    focus = -1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_bias = 15;
          1:       push_bias = 50;
          default: push_bias = 85;
        endcase
        focus = ($urandom_range(3) == 0) ? int'($urandom_range(QUEUES - 1)) : -1;
      end
      if (focus >= 0 && $urandom_range(99) < 75)
        q = 2'(focus);
      else
        q = 2'($urandom_range(QUEUES - 1));
      if ($urandom_range(99) < push_bias)
        send_item(CMD_PUSH, q, pick_value());
      else
        send_item(CMD_POP, q, $urandom);
    end
  endtask

  // Receiver: random back-pressure plus one long hold-off
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int c = 1; c < HOLD_CYCLES; c++)
          @(negedge clk);
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(ok, pop_value);
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    sb         = new();
    sent_cnt   = 0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    command    = CMD_PUSH;
    queue_id   = '0;
    push_value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### k_queues_shared_buffer.f
+incdir+design
design/kqsb_pkg.sv
design/k_queues_shared_buffer.sv
dv/k_queues_shared_buffer_tb.sv
